// ----- src/ssb_pkg.sv -----
// Package for the sprite sort and batch unit.
// Holds shared widths, sort mode codes, operation codes and the queue entry type; no dependencies.
package ssb_pkg;

  localparam int unsigned TexW   = 16;
  localparam int unsigned DepW   = 16;
  localparam int unsigned IdxW   = 6;
  localparam int unsigned VoffW  = 9;
  localparam int unsigned VertsPerSprite = 6;

  // Sort mode codes.
  localparam logic [1:0] ModeTexAsc  = 2'd0;
  localparam logic [1:0] ModeDepDesc = 2'd1;
  localparam logic [1:0] ModeDepAsc  = 2'd2;
  localparam logic [1:0] ModeNone    = 2'd3;

  // Operation codes.
  localparam logic OpAdd = 1'b0;
  localparam logic OpEnd = 1'b1;

  // One command passed from front to back.
  typedef struct packed {
    logic               is_end;
    logic [TexW-1:0]    tex;
    logic [DepW-1:0]    dep;
  } cmd_t;

endpackage

// ----- src/ssb_front.sv -----
// Front end: accepts commands and pushes them into a short queue.
// Depends on ssb_pkg.
module ssb_front #(
  parameter int unsigned QDepth = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ssb_pkg::cmd_t cmd_i,
  input  logic          pop_i,
  output logic          full_o,
  output logic          empty_o,
  output ssb_pkg::cmd_t cmd_o
);

  localparam int unsigned PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;

  ssb_pkg::cmd_t       mem_q [QDepth];
  logic [PtrW-1:0]     wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]       cnt_q, cnt_d;

  assign full_o  = (cnt_q == (PtrW+1)'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign cmd_o   = mem_q[rd_q];

  // Pointer and count update.
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(QDepth-1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(QDepth-1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) cnt_d = cnt_q + 1'b1;
    else if (!push_i && pop_i) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= cmd_i;
  end

endmodule

// ----- src/ssb_back.sv -----
// Back end: inserts records in sorted order, then streams them out on end.
// Depends on ssb_pkg.
module ssb_back #(
  parameter int unsigned MaxSprites = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [1:0]    mode_i,
  input  logic          valid_i,
  input  ssb_pkg::cmd_t cmd_i,
  output logic          pop_o,
  output logic          res_valid_o,
  output logic [ssb_pkg::IdxW-1:0]  sprite_index_o,
  output logic [ssb_pkg::TexW-1:0]  texture_id_out_o,
  output logic [ssb_pkg::VoffW-1:0] vertex_offset_o,
  output logic          new_batch_o,
  output logic          dropped_o,
  output logic          last_o
);

  localparam int unsigned CW = $clog2(MaxSprites + 1);

  localparam logic [1:0] StLoad = 2'd0;
  localparam logic [1:0] StEmit = 2'd1;

  typedef struct packed {
    logic [ssb_pkg::TexW-1:0] tex;
    logic [ssb_pkg::DepW-1:0] dep;
    logic [ssb_pkg::IdxW-1:0] idx;
  } rec_t;

  // Sorted row of cells; each cell is read at its own fixed place.
  rec_t            row_q [MaxSprites];
  logic [CW-1:0]   cnt_q;
  logic            ovf_q;
  logic [1:0]      st_q;
  logic [CW-1:0]   pos_q;
  logic [ssb_pkg::VoffW-1:0] voff_q;
  logic [ssb_pkg::TexW-1:0]  prev_tex_q;

  rec_t                new_rec;
  logic [MaxSprites-1:0] after;   // new record goes strictly before cell k

  assign new_rec.tex = cmd_i.tex;
  assign new_rec.dep = cmd_i.dep;
  assign new_rec.idx = ssb_pkg::IdxW'(cnt_q);

  // Per-cell compare against the incoming record.
  always_comb begin
    for (int k = 0; k < MaxSprites; k++) begin
      case (mode_i)
        ssb_pkg::ModeTexAsc:  after[k] = cmd_i.tex < row_q[k].tex;
        ssb_pkg::ModeDepDesc: after[k] = $signed(cmd_i.dep) > $signed(row_q[k].dep);
        ssb_pkg::ModeDepAsc:  after[k] = $signed(cmd_i.dep) < $signed(row_q[k].dep);
        default:              after[k] = 1'b0;
      endcase
      if (CW'(k) >= cnt_q) after[k] = 1'b1;
    end
  end

  assign pop_o  = valid_i && (st_q == StLoad);

  // Insert into the row: cells at or past the slot shift up by one.
  // While emitting, the row shifts down so the head cell is always next.
  always_ff @(posedge clk_i) begin
    if (st_q == StEmit) begin
      for (int k = 0; k < MaxSprites - 1; k++) row_q[k] <= row_q[k+1];
    end else if (pop_o && !cmd_i.is_end && (cnt_q < CW'(MaxSprites))) begin
      for (int k = MaxSprites - 1; k >= 0; k--) begin
        if (after[k]) begin
          if (k == 0 || !after[(k == 0) ? 0 : k-1]) row_q[k] <= new_rec;
          else row_q[k] <= row_q[(k == 0) ? 0 : k-1];
        end
      end
    end
  end

  rec_t cur;
  assign cur = row_q[0];

  // Control: load records, then emit one result per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= StLoad;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      pos_q       <= '0;
      voff_q      <= '0;
      res_valid_o <= 1'b0;
    end else begin
      res_valid_o <= 1'b0;
      case (st_q)
        StLoad: begin
          if (pop_o) begin
            if (!cmd_i.is_end) begin
              if (cnt_q < CW'(MaxSprites)) cnt_q <= cnt_q + 1'b1;
              else ovf_q <= 1'b1;
            end else if (cnt_q == '0) begin
              ovf_q <= 1'b0;
            end else begin
              st_q   <= StEmit;
              pos_q  <= '0;
              voff_q <= '0;
            end
          end
        end
        StEmit: begin
          res_valid_o <= 1'b1;
          pos_q  <= pos_q + 1'b1;
          voff_q <= voff_q + ssb_pkg::VoffW'(ssb_pkg::VertsPerSprite);
          if (pos_q + 1'b1 == cnt_q) begin
            st_q  <= StLoad;
            cnt_q <= '0;
            ovf_q <= 1'b0;
          end
        end
        default: st_q <= StLoad;
      endcase
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (st_q == StEmit) begin
      sprite_index_o   <= cur.idx;
      texture_id_out_o <= cur.tex;
      vertex_offset_o  <= voff_q;
      new_batch_o      <= (pos_q == '0) || (cur.tex != prev_tex_q);
      dropped_o        <= ovf_q;
      last_o           <= (pos_q + 1'b1 == cnt_q);
      prev_tex_q       <= cur.tex;
    end
  end

endmodule

// ----- src/sprite_sort_and_batch_unit.sv -----
// Top level of the sprite sort and batch unit.
// Depends on ssb_pkg, ssb_front and ssb_back.
//
//  Channel  | Signals                                     | Transfer
//  ---------+---------------------------------------------+---------------------
//  command  | start_i, operation_i, texture_id_i, depth_i | start_i && !busy_o
//  result   | result_valid_o, sprite_index_o ... last_o   | each cycle with strobe
//  config   | sort_mode_we_i, sort_mode_i                 | sort_mode_we_i
//
// Adds are taken one per cycle while busy_o is low; each passes through the queue
// and is then inserted into a sorted row of cells in place.
// An end with N records emits N results, one per cycle; the first result reaches
// the ports once the end has passed the queue, the state and the result registers.
// busy_o rises only when the two-entry queue is full, which happens while a run drains.
// Reset clears counts and the queue. The receiver cannot stall.
module sprite_sort_and_batch_unit #(
  parameter int unsigned MAX_SPRITES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        operation_i,
  input  logic [15:0] texture_id_i,
  input  logic signed [15:0] depth_i,
  input  logic        sort_mode_we_i,
  input  logic [1:0]  sort_mode_i,
  output logic        result_valid_o,
  output logic [5:0]  sprite_index_o,
  output logic [15:0] texture_id_out_o,
  output logic [8:0]  vertex_offset_o,
  output logic        new_batch_o,
  output logic        dropped_o,
  output logic        last_o
);

  logic [1:0]    mode_q;
  ssb_pkg::cmd_t in_cmd, q_cmd;
  logic          q_full, q_empty, pop, push;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mode_q <= ssb_pkg::ModeTexAsc;
    else if (sort_mode_we_i) mode_q <= sort_mode_i;
  end

  assign in_cmd.is_end = (operation_i == ssb_pkg::OpEnd);
  assign in_cmd.tex    = texture_id_i;
  assign in_cmd.dep    = depth_i;
  assign busy_o        = q_full;
  assign push          = start_i && !q_full;

  ssb_front #(.QDepth(2)) u_front (
    .clk_i, .rst_ni,
    .push_i(push), .cmd_i(in_cmd), .pop_i(pop),
    .full_o(q_full), .empty_o(q_empty), .cmd_o(q_cmd)
  );

  ssb_back #(.MaxSprites(MAX_SPRITES)) u_back (
    .clk_i, .rst_ni,
    .mode_i(mode_q), .valid_i(!q_empty), .cmd_i(q_cmd),
    .pop_o(pop),
    .res_valid_o(result_valid_o),
    .sprite_index_o, .texture_id_out_o, .vertex_offset_o,
    .new_batch_o, .dropped_o, .last_o
  );

endmodule

// ----- src/ssb_checker.sv -----
// Port-level checker for the sprite sort and batch unit, bound to the top level.
// Depends only on the top level's ports.
module ssb_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       result_valid_o,
  input logic [8:0] vertex_offset_o,
  input logic       new_batch_o,
  input logic       last_o
);

  // Consecutive results of a run step the vertex offset by six.
  a_voff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |=> !result_valid_o || vertex_offset_o ==
      $past(vertex_offset_o) + 9'd6)
    else $error("vertex offset step");

  // The first result of a run opens a batch.
  a_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && vertex_offset_o == 9'd0 |-> new_batch_o)
    else $error("first result without new batch");

  // Results within a run are back to back.
  a_dense: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |=> result_valid_o)
    else $error("gap inside a run");

endmodule

bind sprite_sort_and_batch_unit ssb_checker u_ssb_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .result_valid_o(result_valid_o),
  .vertex_offset_o(vertex_offset_o), .new_batch_o(new_batch_o), .last_o(last_o)
);

// ----- verif/testbench.sv -----
// Self-checking testbench for the sprite sort and batch unit.
// Depends on ssb_pkg and sprite_sort_and_batch_unit; predicts sorted results itself.
module testbench;

  typedef struct {
    logic            op;
    logic [15:0]     tex;
    logic [15:0]     dep;
  } sprite_cmd_t;

  typedef struct {
    logic [5:0]  idx;
    logic [15:0] tex;
    logic [8:0]  voff;
    logic        new_batch;
    logic        dropped;
    logic        last;
  } sorted_sprite_t;

  typedef struct {
    logic [15:0]        tex;
    logic signed [15:0] dep;
    logic [5:0]         idx;
  } sprite_rec_t;

  localparam int unsigned Capacity = 64;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic        operation_i;
  logic [15:0] texture_id_i;
  logic signed [15:0] depth_i;
  logic        sort_mode_we_i;
  logic [1:0]  sort_mode_i;
  logic        result_valid_o;
  logic [5:0]  sprite_index_o;
  logic [15:0] texture_id_out_o;
  logic [8:0]  vertex_offset_o;
  logic        new_batch_o;
  logic        dropped_o;
  logic        last_o;

  sprite_cmd_t    cmd_queue[$];
  sorted_sprite_t sorted_queue[$];
  sprite_rec_t    shadow_store[Capacity];
  int unsigned    shadow_count;
  logic           shadow_overflow;
  logic [1:0]     shadow_mode;
  int unsigned    idle_pct;
  int unsigned    error_count;

  sprite_sort_and_batch_unit #(.MAX_SPRITES(Capacity)) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .operation_i     (operation_i),
    .texture_id_i    (texture_id_i),
    .depth_i         (depth_i),
    .sort_mode_we_i  (sort_mode_we_i),
    .sort_mode_i     (sort_mode_i),
    .result_valid_o  (result_valid_o),
    .sprite_index_o  (sprite_index_o),
    .texture_id_out_o(texture_id_out_o),
    .vertex_offset_o (vertex_offset_o),
    .new_batch_o     (new_batch_o),
    .dropped_o       (dropped_o),
    .last_o          (last_o)
  );

  // Clock and a single reset at the start of the run.
  initial begin
    clk_i  = 1'b0;
    rst_ni = 1'b0;
    fork
      forever #2 clk_i = ~clk_i;
      begin
        repeat (3) @(posedge clk_i);
        rst_ni <= 1'b1;
      end
    join_none
  end

  // True when record a must come strictly ahead of record b in the given mode.
  function automatic logic sorts_ahead(sprite_rec_t a, sprite_rec_t b, logic [1:0] mode);
    case (mode)
      ssb_pkg::ModeTexAsc:  return a.tex < b.tex;
      ssb_pkg::ModeDepDesc: return a.dep > b.dep;
      ssb_pkg::ModeDepAsc:  return a.dep < b.dep;
      default:              return 1'b0;
    endcase
  endfunction

  // Update the shadow store for one accepted transfer and queue any sorted results.
  task automatic predict_batch(logic op, logic [15:0] tex, logic [15:0] dep);
    sprite_rec_t    order[Capacity];
    sprite_rec_t    cur;
    sorted_sprite_t res;
    int             j;
    if (op == ssb_pkg::OpAdd) begin
      if (shadow_count < Capacity) begin
        shadow_store[shadow_count] = '{tex, dep, shadow_count[5:0]};
        shadow_count++;
      end else begin
        shadow_overflow = 1'b1;
      end
      return;
    end
    for (int i = 0; i < shadow_count; i++) order[i] = shadow_store[i];
    // Stable insertion sort keeps equal keys in arrival order.
    for (int i = 1; i < shadow_count; i++) begin
      cur = order[i];
      j = i;
      while (j > 0 && sorts_ahead(cur, order[j-1], shadow_mode)) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = cur;
    end
    for (int i = 0; i < shadow_count; i++) begin
      res.idx       = order[i].idx;
      res.tex       = order[i].tex;
      res.voff      = 9'(i * ssb_pkg::VertsPerSprite);
      res.new_batch = (i == 0) ? 1'b1 : (order[i].tex != order[(i == 0) ? 0 : i-1].tex);
      res.dropped   = shadow_overflow;
      res.last      = (i + 1 == shadow_count);
      sorted_queue.push_back(res);
    end
    shadow_count    = 0;
    shadow_overflow = 1'b0;
  endtask

  // Driver: predicts each accepted transfer and presents the next command.
  always @(posedge clk_i or negedge rst_ni) begin
    sprite_cmd_t nxt;
    logic        advance;
    if (!rst_ni) begin
      start_i      <= 1'b0;
      operation_i  <= ssb_pkg::OpAdd;
      texture_id_i <= '0;
      depth_i      <= '0;
    end else begin
      advance = !start_i || !busy_o;
      if (start_i && !busy_o) predict_batch(operation_i, texture_id_i, depth_i);
      if (advance) begin
        if (cmd_queue.size() > 0 && $urandom_range(99) >= idle_pct) begin
          nxt = cmd_queue.pop_front();
          operation_i  <= nxt.op;
          texture_id_i <= nxt.tex;
          depth_i      <= nxt.dep;
          start_i      <= 1'b1;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed result must match the oldest expectation.
  always @(posedge clk_i) begin
    sorted_sprite_t exp_res;
    if (rst_ni && result_valid_o) begin
      if (sorted_queue.size() == 0) begin
        $display("%0t: unexpected result idx=%0d tex=%h", $time, sprite_index_o,
                 texture_id_out_o);
        error_count++;
      end else begin
        exp_res = sorted_queue.pop_front();
        if (sprite_index_o !== exp_res.idx || texture_id_out_o !== exp_res.tex ||
            vertex_offset_o !== exp_res.voff || new_batch_o !== exp_res.new_batch ||
            dropped_o !== exp_res.dropped || last_o !== exp_res.last) begin
          $display("%0t: expected idx=%0d tex=%h voff=%0d nb=%b drop=%b last=%b", $time,
                   exp_res.idx, exp_res.tex, exp_res.voff, exp_res.new_batch,
                   exp_res.dropped, exp_res.last);
          $display("%0t: actual   idx=%0d tex=%h voff=%0d nb=%b drop=%b last=%b", $time,
                   sprite_index_o, texture_id_out_o, vertex_offset_o, new_batch_o,
                   dropped_o, last_o);
          error_count++;
        end
      end
    end
  end

  task automatic queue_cmd(logic op, logic [15:0] tex, logic [15:0] dep);
    cmd_queue.push_back('{op, tex, dep});
  endtask

  // Wait until every command is taken, every result seen and the unit is quiet.
  task automatic wait_quiet();
    while (cmd_queue.size() > 0 || start_i || busy_o || sorted_queue.size() > 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_mode(logic [1:0] mode);
    sort_mode_we_i <= 1'b1;
    sort_mode_i    <= mode;
    @(posedge clk_i);
    shadow_mode = mode;
    sort_mode_we_i <= 1'b0;
  endtask

  // Random batch: mostly small sizes, textures from a narrow set to form batches.
  task automatic queue_random_batch();
    int unsigned n;
    logic [15:0] tex;
    logic [15:0] dep;
    n = ($urandom_range(9) == 0) ? $urandom_range(20) : $urandom_range(7);
    for (int i = 0; i < n; i++) begin
      tex = ($urandom_range(2) == 0) ? 16'($urandom) : 16'($urandom_range(3));
      dep = ($urandom_range(2) == 0) ? 16'($urandom) : 16'($urandom_range(3) - 1);
      queue_cmd(ssb_pkg::OpAdd, tex, dep);
    end
    queue_cmd(ssb_pkg::OpEnd, 16'($urandom), 16'($urandom));
  endtask

  // Stimulus: directed batches first, then random phases with varied idling.
  initial begin
    int unsigned idle_by_phase[4] = '{0, 61, 0, 8};
    sort_mode_we_i = 1'b0;
    sort_mode_i    = ssb_pkg::ModeTexAsc;
    shadow_mode    = ssb_pkg::ModeTexAsc;
    shadow_count   = 0;
    shadow_overflow = 1'b0;
    idle_pct       = 0;
    error_count    = 0;
    @(posedge rst_ni);
    @(posedge clk_i);

    // Field extremes, equal textures and equal depths, texture ascending.
    write_mode(ssb_pkg::ModeTexAsc);
    queue_cmd(ssb_pkg::OpAdd, 16'hFFFF, 16'h8000);
    queue_cmd(ssb_pkg::OpAdd, 16'h0000, 16'h7FFF);
    queue_cmd(ssb_pkg::OpAdd, 16'h0005, 16'h0000);
    queue_cmd(ssb_pkg::OpAdd, 16'h0005, 16'h0000);
    queue_cmd(ssb_pkg::OpAdd, 16'h0000, 16'hFFFF);
    queue_cmd(ssb_pkg::OpEnd, 16'h0000, 16'h0000);
    // An empty end emits nothing.
    queue_cmd(ssb_pkg::OpEnd, 16'hFFFF, 16'hFFFF);
    wait_quiet();

    // Depth back to front, then front to back, on the same records.
    for (int m = ssb_pkg::ModeDepDesc; m <= ssb_pkg::ModeDepAsc; m++) begin
      write_mode(m[1:0]);
      queue_cmd(ssb_pkg::OpAdd, 16'h1234, 16'h8000);
      queue_cmd(ssb_pkg::OpAdd, 16'h1234, 16'h7FFF);
      queue_cmd(ssb_pkg::OpAdd, 16'hABCD, 16'h0100);
      queue_cmd(ssb_pkg::OpAdd, 16'h0001, 16'h0100);
      queue_cmd(ssb_pkg::OpEnd, 16'h0000, 16'h0000);
      wait_quiet();
    end

    // Store full: extra adds are discarded and the dropped flag is raised.
    write_mode(ssb_pkg::ModeNone);
    for (int i = 0; i < Capacity + 2; i++) begin
      queue_cmd(ssb_pkg::OpAdd, 16'(i / 3), 16'($urandom));
    end
    queue_cmd(ssb_pkg::OpEnd, 16'h0000, 16'h0000);
    // Overflow seen; the end of its run clears it, and an empty end then emits nothing.
    queue_cmd(ssb_pkg::OpEnd, 16'h0000, 16'h0000);
    queue_cmd(ssb_pkg::OpAdd, 16'h0007, 16'h0007);
    queue_cmd(ssb_pkg::OpEnd, 16'h0000, 16'h0000);
    wait_quiet();

    // Random phases over every mode and idling level.
    for (int p = 0; p < 8; p++) begin
      write_mode((p < 4) ? p[1:0] : 2'($urandom));
      idle_pct = idle_by_phase[p % 4];
      queue_random_batch();
      wait_quiet();
    end

    repeat (20) @(posedge clk_i);
    if (error_count == 0 && sorted_queue.size() == 0) begin
      $display("** sprite_sort_and_batch_unit: PASSED **");
    end else begin
      $display("** sprite_sort_and_batch_unit: FAILED **");
    end
    $finish;
  end

  // Run limit far above the slowest correct run.
  initial begin
    #400000;
    $display("** sprite_sort_and_batch_unit: FAILED **");
    $finish;
  end

endmodule
